/* src/sisa_pkg.sv */
// ----------------------------------------------------------------------------
// sisa_pkg: shared types and helpers of the signed-index scatter store
// Holds the command codes, the decoded operation that travels from the front
// end to the back end, and the Q16.16 saturation helpers.
// ----------------------------------------------------------------------------
package sisa_pkg;

  // Input field widths.
  localparam int CMD_W   = 2;
  localparam int SIDX_W  = 13;
  localparam int ADDR_W  = 12;
  localparam int DATA_W  = 32;

  // Default store depth and configuration reset value (1.0 in Q16.16).
  localparam int VEC_DEPTH_DEFAULT = 4096;
  localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ACC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // Operation handed from the front end to the back end.
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic                     neg;
    logic                     in_range;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W:0]   val;   // value with the index sign applied, exact
    logic                     last;
  } op_t;

  // Clamp a 33-bit signed value to the 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] == v[DATA_W-1]) begin
      r = v[DATA_W-1:0];
    end else if (v[DATA_W]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Negate with saturation: the most negative value maps to the most positive.
  function automatic logic signed [DATA_W-1:0] neg_sat32(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W:0] w;
    w = -(DATA_W+1)'(v);
    return sat33(w);
  endfunction

endpackage

/* src/sisa_front.sv */
// ----------------------------------------------------------------------------
// sisa_front: input decode and classification
// Decodes the signed index, applies the sign to the value and drops items
// that leave the store unchanged before they reach the queue.
// ----------------------------------------------------------------------------
module sisa_front #(
  parameter int VEC_DEPTH = sisa_pkg::VEC_DEPTH_DEFAULT
) (
  input  logic                                  push,
  output logic                                  full,
  input  logic [sisa_pkg::CMD_W-1:0]            cmd,
  input  logic signed [sisa_pkg::SIDX_W-1:0]    signed_index,
  input  logic signed [sisa_pkg::DATA_W-1:0]    value,
  input  logic                                  element_end,
  input  logic                                  q_full,
  input  logic                                  clearing,
  output logic                                  enq,
  output sisa_pkg::op_t                         enq_op
);

  logic                                neg;
  logic [sisa_pkg::ADDR_W-1:0]         addr;
  logic                                in_range;
  logic signed [sisa_pkg::DATA_W:0]    val_ext;
  logic                                keep;

  // Index decode: a negative index n addresses entry -1-n, the bitwise inverse.
  assign neg      = signed_index[sisa_pkg::SIDX_W-1];
  assign addr     = neg ? ~signed_index[sisa_pkg::ADDR_W-1:0]
                        : signed_index[sisa_pkg::ADDR_W-1:0];
  assign in_range = 32'(addr) < 32'(VEC_DEPTH);
  assign val_ext  = (sisa_pkg::DATA_W+1)'(value);

  // Only reads and in-range writes have any effect downstream.
  assign keep = (cmd == sisa_pkg::CMD_READ) ||
                (((cmd == sisa_pkg::CMD_ACC) || (cmd == sisa_pkg::CMD_SET)) && in_range);

  // No transaction is taken while the queue is full or the store is cleared.
  assign full = q_full || clearing;
  assign enq  = push && !full && keep;

  always_comb begin
    enq_op.cmd      = cmd;
    enq_op.neg      = neg;
    enq_op.in_range = in_range;
    enq_op.addr     = addr;
    enq_op.val      = neg ? -val_ext : val_ext;
    enq_op.last     = element_end;
  end

endmodule

/* src/sisa_queue.sv */
// ----------------------------------------------------------------------------
// sisa_queue: short operation queue between front and back end
// A two-entry register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module sisa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  sisa_pkg::op_t enq_op,
  output logic          q_full,
  input  logic          deq,
  output logic          q_empty,
  output sisa_pkg::op_t head_op
);

  sisa_pkg::op_t                 slots [sisa_pkg::QUEUE_DEPTH];
  logic [sisa_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sisa_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sisa_pkg::QCNT_W-1:0]   count;

  assign q_full  = count == sisa_pkg::QCNT_W'(sisa_pkg::QUEUE_DEPTH);
  assign q_empty = count == '0;
  assign head_op = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_op;
    end
  end

endmodule

/* src/sisa_back.sv */
// ----------------------------------------------------------------------------
// sisa_back: vector store and read-modify-write sequencer
// Clears the store after reset, then takes one operation from the queue at a
// time: reads the entry and forms the scaled product, then writes the entry
// or delivers the read result into the output register.
// ----------------------------------------------------------------------------
module sisa_back #(
  parameter int VEC_DEPTH = sisa_pkg::VEC_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [sisa_pkg::DATA_W-1:0]  alpha_gain,
  input  logic                                q_empty,
  input  sisa_pkg::op_t                       head_op,
  output logic                                deq,
  output logic                                clearing,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [sisa_pkg::DATA_W-1:0]  read_value,
  output logic [sisa_pkg::ADDR_W-1:0]         entry_index,
  output logic                                end_of_run
);

  localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int XW = (AW > sisa_pkg::ADDR_W) ? AW : sisa_pkg::ADDR_W;
  localparam int DW = sisa_pkg::DATA_W;
  localparam int PW = 2 * DW + 1;
  localparam int SW = PW - 16 + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic signed [DW-1:0]  mem [VEC_DEPTH];

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [AW-1:0]         clr_cnt;
  sisa_pkg::op_t         op;
  logic signed [DW-1:0]  rd_data;
  logic signed [PW-1:0]  prod;

  logic                  out_valid;
  logic                  out_free;
  logic                  done;
  logic [XW-1:0]         head_addr_x;
  logic [XW-1:0]         op_addr_x;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic signed [DW-1:0]  mem_wd;
  logic signed [SW-1:0]  sum;
  logic signed [DW-1:0]  acc_res;
  logic signed [DW-1:0]  entry;
  logic signed [DW-1:0]  rd_res;

  assign head_addr_x = XW'(head_op.addr);
  assign op_addr_x   = XW'(op.addr);

  assign clearing = state == ST_CLEAR;
  assign deq      = (state == ST_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;
  assign done     = (op.cmd != sisa_pkg::CMD_READ) || out_free;

  // Accumulate: floor of the product over 2^16 added to the entry, saturated.
  assign sum = SW'(rd_data) + SW'($signed(prod[PW-1:16]));
  always_comb begin
    if (sum[SW-1:DW-1] == {(SW-DW+1){1'b0}} || sum[SW-1:DW-1] == {(SW-DW+1){1'b1}}) begin
      acc_res = sum[DW-1:0];
    end else if (sum[SW-1]) begin
      acc_res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      acc_res = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Read: out-of-range entries read as zero, then the index sign is applied.
  assign entry  = op.in_range ? rd_data : '0;
  assign rd_res = op.neg ? sisa_pkg::neg_sat32(entry) : entry;

  // Store write port: zero fill during clearing, else the executing operation.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = op_addr_x[AW-1:0];
    mem_wd = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
      end
      ST_EXEC: begin
        if (op.cmd == sisa_pkg::CMD_ACC) begin
          mem_we = 1'b1;
          mem_wd = acc_res;
        end else if (op.cmd == sisa_pkg::CMD_SET) begin
          mem_we = 1'b1;
          mem_wd = sisa_pkg::sat33(op.val);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(VEC_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if ((state == ST_EXEC) && (op.cmd == sisa_pkg::CMD_READ) && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation capture and product register.
  always_ff @(posedge clk) begin
    if (deq) begin
      op   <= head_op;
      prod <= PW'(alpha_gain) * PW'(head_op.val);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if ((state == ST_EXEC) && (op.cmd == sisa_pkg::CMD_READ) && out_free) begin
      read_value  <= rd_res;
      entry_index <= op.addr;
      end_of_run  <= op.last;
    end
  end

  // Vector store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (deq) begin
      rd_data <= mem[head_addr_x[AW-1:0]];
    end
  end

  assign empty = !out_valid;

endmodule

/* src/signed_index_scatter_accumulate.sv */
// ----------------------------------------------------------------------------
// signed_index_scatter_accumulate: signed-index scatter/gather Q16.16 store
// Top level: configuration register, front-end decode, operation queue and
// the store back end.
// ----------------------------------------------------------------------------
// After reset the store is zeroed by a clearing pass over all VEC_DEPTH entries,
// during which full stays high; configuration writes are taken at any time.
// Each accumulate, set or read then passes through the back end in order:
// first the entry is read from the store and the alpha_gain product formed,
// then the entry is written back or the read result loaded. The front end
// accepts a transaction every cycle while the two-entry queue has room, so
// short bursts enter at full speed; the back end takes a new item only once
// the last one is through. Unused commands and out-of-range writes are
// dropped at the front end and never reach the back end. A read result waits
// in the output register until popped; only a further read stalls behind it.
module signed_index_scatter_accumulate #(
  parameter int VEC_DEPTH = sisa_pkg::VEC_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [sisa_pkg::DATA_W-1:0]  cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic [sisa_pkg::CMD_W-1:0]          cmd,
  input  logic signed [sisa_pkg::SIDX_W-1:0]  signed_index,
  input  logic signed [sisa_pkg::DATA_W-1:0]  value,
  input  logic                                element_end,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [sisa_pkg::DATA_W-1:0]  read_value,
  output logic [sisa_pkg::ADDR_W-1:0]         entry_index,
  output logic                                end_of_run
);

  logic signed [sisa_pkg::DATA_W-1:0]  alpha_gain;
  logic                                q_full;
  logic                                q_empty;
  logic                                enq;
  logic                                deq;
  logic                                clearing;
  sisa_pkg::op_t                       enq_op;
  sisa_pkg::op_t                       head_op;

  // Gain register, writable in any cycle.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= sisa_pkg::ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alpha_gain <= cfg_data;
    end
  end

  sisa_front #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_front (
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .signed_index (signed_index),
    .value        (value),
    .element_end  (element_end),
    .q_full       (q_full),
    .clearing     (clearing),
    .enq          (enq),
    .enq_op       (enq_op)
  );

  sisa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_op  (enq_op),
    .q_full  (q_full),
    .deq     (deq),
    .q_empty (q_empty),
    .head_op (head_op)
  );

  sisa_back #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .alpha_gain  (alpha_gain),
    .q_empty     (q_empty),
    .head_op     (head_op),
    .deq         (deq),
    .clearing    (clearing),
    .empty       (empty),
    .pop         (pop),
    .read_value  (read_value),
    .entry_index (entry_index),
    .end_of_run  (end_of_run)
  );

  // The clearing pass must block every input transaction.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (full && !enq))
    else $error("input accepted during clearing pass");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq |-> !q_full)
    else $error("queue overflow");

  // The back end never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    deq |-> !q_empty)
    else $error("queue underflow");

  // A result offered to the consumer comes only after the clearing pass.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> empty)
    else $error("result present during clearing pass");

endmodule

/* test/tb_signed_index_scatter_accumulate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_index_scatter_accumulate: testbench of the signed-index store
// Drives accumulate, set, read and unused commands through the push/full
// queue interface and pops read results at random. A scoreboard class keeps
// its own copy of the Q16.16 store and the gain, predicts every read, and
// compares each popped result field by field. The gain register is rewritten
// between phases, including its extremes, while the block is idle.
// ----------------------------------------------------------------------------
module tb_signed_index_scatter_accumulate;

  localparam int STORE_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 8;
  localparam logic [sisa_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // One read result as it leaves the block.
  typedef struct packed {
    logic signed [sisa_pkg::DATA_W-1:0] read_value;
    logic [sisa_pkg::ADDR_W-1:0]        entry_index;
    logic                               end_of_run;
  } read_result_t;

  // Mirror of the store and the gain; predicts the result of each read.
  class store_mirror;
    logic signed [sisa_pkg::DATA_W-1:0] entries [STORE_DEPTH];
    logic signed [sisa_pkg::DATA_W-1:0] gain;
    read_result_t                       reads_due [$];
    int                                 errors;

    function new();
      foreach (entries[i]) entries[i] = '0;
      gain = sisa_pkg::ALPHA_RESET;
      errors = 0;
    endfunction

    function logic signed [sisa_pkg::DATA_W-1:0] clamp32(input longint x);
      if (x > SAT_HI) return 32'sh7fffffff;
      if (x < SAT_LO) return 32'sh80000000;
      return 32'(x);
    endfunction

    function int reads_waiting();
      return reads_due.size();
    endfunction

    // Apply one accepted transaction to the mirror.
    function void apply_item(input logic [sisa_pkg::CMD_W-1:0] c,
                             input logic signed [sisa_pkg::SIDX_W-1:0] si,
                             input logic signed [sisa_pkg::DATA_W-1:0] v, input logic e);
      int           sidx;
      int           addr;
      bit           neg;
      bit           in_range;
      longint       signed_val;
      longint       product;
      longint       entry;
      read_result_t res;
      sidx = si;
      neg = (sidx < 0);
      addr = neg ? (-1 - sidx) : sidx;
      in_range = (addr < STORE_DEPTH);
      signed_val = neg ? -longint'(v) : longint'(v);
      case (c)
        sisa_pkg::CMD_ACC: begin
          // The product is exact; the shift floors and only the sum saturates.
          if (in_range) begin
            product = longint'(gain) * signed_val;
            entries[addr] = clamp32(longint'(entries[addr]) + (product >>> 16));
          end
        end
        sisa_pkg::CMD_SET: begin
          if (in_range) entries[addr] = clamp32(signed_val);
        end
        sisa_pkg::CMD_READ: begin
          entry = in_range ? longint'(entries[addr]) : 64'sd0;
          res.read_value = clamp32(neg ? -entry : entry);
          res.entry_index = addr[sisa_pkg::ADDR_W-1:0];
          res.end_of_run = e;
          reads_due.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one popped result with the oldest predicted read.
    task check_read(input read_result_t got);
      read_result_t want;
      if (reads_due.size() == 0) begin
        report($sformatf("unexpected result value %h index %0d", got.read_value,
                         got.entry_index));
      end else begin
        want = reads_due.pop_front();
        if (got.read_value !== want.read_value)
          report($sformatf("read_value %h, predicted %h (index %0d)", got.read_value,
                           want.read_value, want.entry_index));
        if (got.entry_index !== want.entry_index)
          report($sformatf("entry_index %0d, predicted %0d", got.entry_index,
                           want.entry_index));
        if (got.end_of_run !== want.end_of_run)
          report($sformatf("end_of_run %b, predicted %b", got.end_of_run, want.end_of_run));
      end
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic signed [sisa_pkg::DATA_W-1:0] cfg_data;
  logic                               push;
  logic                               full;
  logic [sisa_pkg::CMD_W-1:0]         cmd;
  logic signed [sisa_pkg::SIDX_W-1:0] signed_index;
  logic signed [sisa_pkg::DATA_W-1:0] value;
  logic                               element_end;
  logic                               empty;
  logic                               pop;
  logic signed [sisa_pkg::DATA_W-1:0] read_value;
  logic [sisa_pkg::ADDR_W-1:0]        entry_index;
  logic                               end_of_run;

  // Stimulus controls shared with the result side.
  logic                     steady;
  logic                     hold_req;
  int                       items_sent;
  int                       cycle_count;
  store_mirror              mirror;

  signed_index_scatter_accumulate dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .signed_index (signed_index),
    .value        (value),
    .element_end  (element_end),
    .empty        (empty),
    .pop          (pop),
    .read_value   (read_value),
    .entry_index  (entry_index),
    .end_of_run   (end_of_run)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side: check each popped transaction, then choose the next pop.
  // A hold request makes this side keep pop low for a long counted stretch.
  initial begin
    int           hold_left;
    read_result_t got;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.read_value = read_value;
        got.entry_index = entry_index;
        got.end_of_run = end_of_run;
        mirror.check_read(got);
      end
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 22);
      end
    end
  end

  // Offer one transaction and wait until it is accepted.
  task automatic push_item(input logic [sisa_pkg::CMD_W-1:0] c,
                           input logic signed [sisa_pkg::SIDX_W-1:0] si,
                           input logic signed [sisa_pkg::DATA_W-1:0] v, input logic e,
                           input bit may_idle);
    while (may_idle && !steady && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    signed_index <= si;
    value <= v;
    element_end <= e;
    do @(posedge clk); while (full);
    mirror.apply_item(c, si, v, e);
    if (c != CMD_NONE) items_sent++;
  endtask

  // Stop offering, wait for every predicted read, then let writes drain.
  task automatic settle();
    push <= 1'b0;
    while (mirror.reads_waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic signed [sisa_pkg::DATA_W-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.gain = g;
  endtask

  // Indices mostly fall in a small window so that entries are hit repeatedly.
  function automatic logic signed [sisa_pkg::SIDX_W-1:0] pick_index();
    int j;
    if ($urandom_range(99) < 30) return sisa_pkg::SIDX_W'($urandom);
    j = $urandom_range(0, 15);
    return $urandom_range(1) ? sisa_pkg::SIDX_W'(-1 - j) : sisa_pkg::SIDX_W'(j);
  endfunction

  function automatic logic signed [sisa_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(1) ? 32'sd1 : -32'sd1;
      3, 4, 5: return sisa_pkg::DATA_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return sisa_pkg::DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [sisa_pkg::DATA_W-1:0] gain_for(input int phase);
    case (phase)
      1: return 32'sh00008000;
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      4: return sisa_pkg::DATA_W'($urandom);
      5: return 32'sh00000000;
      6: return 32'shffff0000;
      default: return 32'shffff8000;
    endcase
  endfunction

  function automatic logic [sisa_pkg::CMD_W-1:0] CMD_WIDTH_CAST(input int unsigned raw);
    return raw[sisa_pkg::CMD_W-1:0];
  endfunction

  // Edge cases at a gain of 1.0.
  task automatic run_directed();
    push_item(sisa_pkg::CMD_SET, 0, 32'sh7fffffff, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, 0, 32'sh0, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, -1, 32'shffffffff, 1'b1, 1);
    push_item(sisa_pkg::CMD_SET, -1, 32'sh80000000, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, 0, 32'sh0, 1'b1, 1);
    push_item(sisa_pkg::CMD_SET, 4095, 32'sh80000000, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, -4096, 32'sh0, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, 4095, 32'sh0, 1'b1, 1);
    push_item(sisa_pkg::CMD_ACC, 4095, -32'sd1, 1'b0, 1);
    push_item(sisa_pkg::CMD_ACC, 0, 32'sd1, 1'b1, 1);
    push_item(sisa_pkg::CMD_READ, 4095, 32'sh0, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, 0, 32'sh0, 1'b1, 1);
    push_item(CMD_NONE, 5, 32'sh12345678, 1'b1, 1);
    push_item(sisa_pkg::CMD_READ, 5, 32'sh0, 1'b0, 1);
    // Negating the most negative value is exact inside an accumulate.
    push_item(sisa_pkg::CMD_ACC, -6, 32'sh80000000, 1'b0, 1);
    push_item(sisa_pkg::CMD_READ, 5, 32'sh0, 1'b1, 1);
    // Back-to-back updates of one entry.
    push_item(sisa_pkg::CMD_SET, 6, 32'sh00018000, 1'b0, 0);
    push_item(sisa_pkg::CMD_ACC, 6, 32'sh00000001, 1'b0, 0);
    push_item(sisa_pkg::CMD_ACC, -7, 32'sh00020000, 1'b1, 0);
    push_item(sisa_pkg::CMD_READ, -7, 32'shffffffff, 1'b1, 0);
    push_item(sisa_pkg::CMD_READ, 6, 32'sh0, 1'b0, 0);
  endtask

  // Mostly element vectors of updates read back afterward, plus random noise.
  task automatic run_random(input int count);
    int                                 target;
    int                                 len;
    logic signed [sisa_pkg::SIDX_W-1:0] ids [8];
    logic [sisa_pkg::CMD_W-1:0]         c;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          ids[k] = pick_index();
          c = ($urandom_range(99) < 80) ? sisa_pkg::CMD_ACC : sisa_pkg::CMD_SET;
          push_item(c, ids[k], pick_value(), k == len - 1, 1);
        end
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(3) != 0)
            push_item(sisa_pkg::CMD_READ, ids[k], sisa_pkg::DATA_W'($urandom),
                      k == len - 1, 1);
        end
      end else begin
        push_item(CMD_WIDTH_CAST($urandom_range(3)), sisa_pkg::SIDX_W'($urandom),
                  pick_value(), 1'($urandom_range(1)), 1);
      end
    end
  endtask

  // Hold the result side off and keep offering reads until the input stalls.
  task automatic fill_while_held();
    push <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 40; k++)
      push_item(sisa_pkg::CMD_READ, pick_index(), sisa_pkg::DATA_W'($urandom),
                1'($urandom_range(1)), 0);
  endtask

  // Main sequence.
  initial begin
    mirror = new();
    items_sent = 0;
    rst <= 1'b1;
    push <= 1'b0;
    cmd <= sisa_pkg::CMD_ACC;
    signed_index <= '0;
    value <= '0;
    element_end <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    steady <= 1'b0;
    hold_req <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(PHASE_ITEMS);
    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      settle();
      write_gain(gain_for(phase));
      steady <= (phase == 4);
      if (phase == 2) fill_while_held();
      run_random(PHASE_ITEMS);
    end
    settle();

    if (mirror.errors == 0 && mirror.reads_waiting() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
